@@ sv/cmac_pkg.sv @@
// ----------------------------------------------------------------------------
// cmac_pkg: shared types and constants for the centered moving average
// Holds the width and reset value of the window radius register.
// ----------------------------------------------------------------------------
package cmac_pkg;

   localparam int unsigned CSR_W = 4;
   localparam int unsigned CSR_RESET = 1;

   typedef logic [CSR_W-1:0] csr_type;

endpackage

@@ sv/centered_moving_average_clamped.sv @@
// ----------------------------------------------------------------------------
// centered_moving_average_clamped: centered box average with clamped ends
// Smooths signed samples over a window of radius R held in a ring store,
// rounding to nearest with ties away from zero; a tlast item flushes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  req      in         req_tvalid / req_tready  tdata: sample, tlast: is_last
//  rsp      out        rsp_tvalid / rsp_tready  tdata: smoothed, tlast: last_out
//  csr      in         csr_wen                  csr_wdata: window_radius
//
//  each result sums a window of w samples, w being its window count (1 to 2R+1),
//  and divides by w; SUM_W = SAMPLE_BITS + 5 at the default R limit. The steps
//  are setup, sum (one store read per window sample, drained through the
//  registered read), prep, divide at one quotient bit per cycle, then emit.
//  an item is accepted in idle and decided on before its first result, or returns to idle if it yields none;
//  a flush runs result by result.
//  reset is synchronous and clears all sequence state; the store needs no clearing.
//  a result waiting in the output register holds back the next result in emit, and with it the input.
// ----------------------------------------------------------------------------
module centered_moving_average_clamped #(
   parameter int unsigned MAX_RADIUS = 15,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned STORE_DEPTH = 64,
   localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [DATA_W-1:0]   req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_tdata,   // [SAMPLE_BITS-1:0] smoothed
   output logic                rsp_tlast,
   input  logic                csr_wen,
   input  cmac_pkg::csr_type   csr_wdata
);

   localparam int unsigned DEPTH_LIM = (STORE_DEPTH - 1) / 3;
   localparam int unsigned RAD_LIM = (MAX_RADIUS < DEPTH_LIM) ? MAX_RADIUS : DEPTH_LIM;
   localparam int unsigned RAD_W = $clog2(RAD_LIM + 1);
   localparam int unsigned CNT_W = RAD_W + 1;
   localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
   localparam int unsigned DIV_CW = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SETUP,
      ST_SUM,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   cmac_pkg::csr_type       window_radius_ff;
   logic [RAD_W-1:0]        radius_ff;
   logic [ADDR_W-1:0]       wp_ff;
   logic [CNT_W-1:0]        seen_ff;
   logic [CNT_W-1:0]        pending_ff;
   logic [RAD_W-1:0]        emit_idx_ff;
   logic                    last_ff;
   logic                    smooth_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [CNT_W-1:0]        issue_ff;
   logic                    rvalid_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [SUM_W-1:0]        acc_ff;
   logic                    neg_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [DIV_CW-1:0]       div_cnt_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]  rsp_data_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic                    can_load;
   logic [RAD_W-1:0]        radius_in;
   logic [CNT_W-1:0]        two_r;
   logic [CNT_W-1:0]        win_max;
   logic [CNT_W-1:0]        pend_m1;
   logic [RAD_W-1:0]        left_in;
   logic [RAD_W-1:0]        right_in;
   logic [CNT_W-1:0]        count_in;
   logic [ADDR_W:0]         base_tmp;
   logic [ADDR_W-1:0]       addr_in;
   logic [ADDR_W-1:0]       addr_inc;
   logic [ADDR_W-1:0]       wp_inc;
   logic [SAMPLE_BITS-1:0]  rd_data;
   logic [SUM_W-1:0]        rd_ext;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        quo_in;
   logic [CNT_W:0]          rem_shift;
   logic                    rem_ge;
   logic [CNT_W:0]          rem_diff;
   logic [SAMPLE_BITS-1:0]  result_in;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign can_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (int'(window_radius_ff) > int'(RAD_LIM)) begin
         radius_in = RAD_W'(RAD_LIM);
      end else begin
         radius_in = window_radius_ff[RAD_W-1:0];
      end
   end

   assign two_r = {radius_ff, 1'b0};
   assign win_max = {radius_ff, 1'b1};
   assign pend_m1 = pending_ff - CNT_W'(1);

   // window clamped to samples already emitted on the left, still held on the right
   always_comb begin
      left_in = '0;
      right_in = '0;
      if (smooth_ff) begin
         left_in = (emit_idx_ff < radius_ff) ? emit_idx_ff : radius_ff;
         right_in = (pend_m1 < {1'b0, radius_ff}) ? pend_m1[RAD_W-1:0] : radius_ff;
      end
   end

   assign count_in = {1'b0, left_in} + {1'b0, right_in} + CNT_W'(1);

   // oldest pending slot minus the left reach, wrapped into the ring
   assign base_tmp = {1'b0, wp_ff} + (ADDR_W + 1)'(STORE_DEPTH)
                   - (ADDR_W + 1)'(pending_ff) - (ADDR_W + 1)'(left_in);
   assign addr_in = (base_tmp >= (ADDR_W + 1)'(STORE_DEPTH))
                  ? ADDR_W'(base_tmp - (ADDR_W + 1)'(STORE_DEPTH))
                  : base_tmp[ADDR_W-1:0];

   assign addr_inc = (addr_ff == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr_ff + ADDR_W'(1);
   assign wp_inc = (wp_ff == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);

   assign rd_ext = {{CNT_W{rd_data[SAMPLE_BITS-1]}}, rd_data};

   // rounding: magnitude plus half the count, then truncating division
   assign mag = acc_ff[SUM_W-1] ? (~acc_ff + SUM_W'(1)) : acc_ff;
   assign quo_in = mag + SUM_W'(count_ff >> 1);

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_ge = (rem_shift >= {1'b0, count_ff});
   assign rem_diff = rem_shift - {1'b0, count_ff};

   assign result_in = neg_ff ? (~quo_ff[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                             : quo_ff[SAMPLE_BITS-1:0];

   cmac_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (req_tdata[SAMPLE_BITS-1:0]),
      .rd_en   (state_ff == ST_SUM),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         window_radius_ff <= cmac_pkg::csr_type'(cmac_pkg::CSR_RESET);
         radius_ff <= '0;
         wp_ff <= '0;
         seen_ff <= '0;
         pending_ff <= '0;
         emit_idx_ff <= '0;
         rvalid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            window_radius_ff <= csr_wdata;
         end
         // the emit state reloads the output register itself
         if (rsp_valid_ff && rsp_tready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // radius is latched on the first item of a sequence
                  if (seen_ff == '0 && pending_ff == '0) begin
                     radius_ff <= radius_in;
                     emit_idx_ff <= '0;
                  end
                  wp_ff <= wp_inc;
                  if (seen_ff != '1) begin
                     seen_ff <= seen_ff + CNT_W'(1);
                  end
                  pending_ff <= pending_ff + CNT_W'(1);
                  last_ff <= req_tlast;
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (last_ff) begin
                  smooth_ff <= (radius_ff != '0) && (seen_ff >= win_max);
                  state_ff <= ST_SETUP;
               end else if (pending_ff > two_r) begin
                  smooth_ff <= 1'b1;
                  state_ff <= ST_SETUP;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SETUP: begin
               addr_ff <= addr_in;
               issue_ff <= count_in;
               count_ff <= count_in;
               acc_ff <= '0;
               rvalid_ff <= 1'b0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (issue_ff != '0) begin
                  addr_ff <= addr_inc;
                  issue_ff <= issue_ff - CNT_W'(1);
                  rvalid_ff <= 1'b1;
               end else begin
                  rvalid_ff <= 1'b0;
               end
               if (rvalid_ff) begin
                  acc_ff <= acc_ff + rd_ext;
               end
               if (issue_ff == '0 && !rvalid_ff) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               neg_ff <= acc_ff[SUM_W-1];
               quo_ff <= quo_in;
               rem_ff <= '0;
               div_cnt_ff <= DIV_CW'(SUM_W);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff <= {quo_ff[SUM_W-2:0], rem_ge};
               rem_ff <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
               div_cnt_ff <= div_cnt_ff - DIV_CW'(1);
               if (div_cnt_ff == DIV_CW'(1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (can_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= result_in;
                  rsp_last_ff <= last_ff && (pending_ff == CNT_W'(1));
                  pending_ff <= pend_m1;
                  if (last_ff && pending_ff == CNT_W'(1)) begin
                     emit_idx_ff <= '0;
                  end else if (emit_idx_ff != RAD_W'(RAD_LIM)) begin
                     emit_idx_ff <= emit_idx_ff + RAD_W'(1);
                  end
                  if (last_ff) begin
                     if (pending_ff != CNT_W'(1)) begin
                        state_ff <= ST_SETUP;
                     end else begin
                        seen_ff <= '0;
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = DATA_W'(rsp_data_ff);
   assign rsp_tlast = rsp_last_ff;

`ifndef SYNTHESIS
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= win_max)
      else $error("more samples pending than a full window");

   a_steady_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !last_ff) |-> pending_ff == win_max)
      else $error("mid-sequence result without a full window held");

   a_sum_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (count_ff != '0 && count_ff <= win_max))
      else $error("window count out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> rem_ff < count_ff)
      else $error("divider remainder not below the count");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && can_load && last_ff && pending_ff == CNT_W'(1))
      |=> (seen_ff == '0 && pending_ff == '0 && state_ff == ST_IDLE))
      else $error("sequence state not cleared after flush");
`endif

endmodule

@@ sv/cmac_ram.sv @@
// ----------------------------------------------------------------------------
// cmac_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmac_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
